### rtl/core/dfc_pkg.sv
package dfc_pkg;

    localparam int TRIM_BITS   = 12;
    localparam int BIT_W       = $clog2(TRIM_BITS);
    localparam int TRIM_CODE_W = 12;
    localparam int FREQ_W      = 32;
    localparam int CNT_W       = 16;
    localparam int SHIFT_W     = 4;
    localparam int MAX_SHIFT   = (1 << SHIFT_W) - 1;
    localparam int SCALED_W    = FREQ_W + MAX_SHIFT;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_FREQ = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT       = 2'd3;

    localparam logic [FREQ_W-1:0]  RST_TARGET_FREQ = 32'd8000000;
    localparam logic [CNT_W-1:0]   RST_SETTLE      = 16'd10000;
    localparam logic [CNT_W-1:0]   RST_WINDOW      = 16'd4096;
    localparam logic [SHIFT_W-1:0] RST_SHIFT       = 4'd3;

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_SETTLE = 4'b0010,
        PH_WAIT   = 4'b0100,
        PH_MEAS   = 4'b1000
    } t_phase;

    typedef struct packed {
        logic kind;
        logic ref_edge;
    } t_req;

    typedef struct packed {
        logic [TRIM_CODE_W-1:0] trim_code;
        logic                   busy_res;
        logic                   done_res;
        logic [FREQ_W-1:0]      scaled_freq;
    } t_rsp;

    typedef struct packed {
        logic [FREQ_W-1:0]  target_freq_hz;
        logic [CNT_W-1:0]   settle_cycles;
        logic [CNT_W-1:0]   window_ref_edges;
        logic [SHIFT_W-1:0] freq_shift;
    } t_cfg;

endpackage

### rtl/core/dfc_cfg_regs.sv
module dfc_cfg_regs
    import dfc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TARGET_FREQ: n_cfg.target_freq_hz   = i_cfg_wdata[FREQ_W-1:0];
                CFG_SETTLE:      n_cfg.settle_cycles    = i_cfg_wdata[CNT_W-1:0];
                CFG_WINDOW:      n_cfg.window_ref_edges = i_cfg_wdata[CNT_W-1:0];
                CFG_SHIFT:       n_cfg.freq_shift       = i_cfg_wdata[SHIFT_W-1:0];
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_freq_hz   <= RST_TARGET_FREQ;
            r_cfg.settle_cycles    <= RST_SETTLE;
            r_cfg.window_ref_edges <= RST_WINDOW;
            r_cfg.freq_shift       <= RST_SHIFT;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

### rtl/core/dfc_sar_engine.sv
module dfc_sar_engine
    import dfc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_fire,
    input  t_req i_req,
    input  t_cfg i_cfg,
    output t_rsp o_rsp
);

    t_phase               r_phase,        n_phase;
    logic [BIT_W-1:0]     r_bit_index,    n_bit_index;
    logic [TRIM_BITS-1:0] r_trim_value,   n_trim_value;
    logic [CNT_W-1:0]     r_settle_count, n_settle_count;
    logic [CNT_W-1:0]     r_ref_count,    n_ref_count;
    logic [FREQ_W-1:0]    r_tick_count,   n_tick_count;
    logic [FREQ_W-1:0]    r_last_freq,    n_last_freq;
    logic                 done;

    logic [FREQ_W-1:0]                tick_inc;
    logic [CNT_W-1:0]                 ref_inc;
    logic [SCALED_W-1:0]              scaled;
    logic [FREQ_W-1:0]                scaled_sat;
    logic [TRIM_BITS-1:0]             cur_bit;
    logic [TRIM_BITS-1:0]             next_bit;
    logic [TRIM_BITS-1:0]             trim_kept;
    logic [BIT_W-1:0]                 bit_dec;
    logic [TRIM_BITS+TRIM_CODE_W-1:0] trim_pad;

    // measurement datapath
    assign tick_inc   = (r_tick_count == '1) ? r_tick_count : r_tick_count + 1'b1;
    assign ref_inc    = r_ref_count + 1'b1;
    assign scaled     = {{(SCALED_W-FREQ_W){1'b0}}, tick_inc} << i_cfg.freq_shift;
    assign scaled_sat = (|scaled[SCALED_W-1:FREQ_W]) ? '1 : scaled[FREQ_W-1:0];
    assign cur_bit    = {{(TRIM_BITS-1){1'b0}}, 1'b1} << r_bit_index;
    assign bit_dec    = r_bit_index - 1'b1;
    assign next_bit   = {{(TRIM_BITS-1){1'b0}}, 1'b1} << bit_dec;
    assign trim_kept  = (scaled_sat > i_cfg.target_freq_hz) ? (r_trim_value & ~cur_bit)
                                                            : r_trim_value;

    always_comb begin
        n_phase        = r_phase;
        n_bit_index    = r_bit_index;
        n_trim_value   = r_trim_value;
        n_settle_count = r_settle_count;
        n_ref_count    = r_ref_count;
        n_tick_count   = r_tick_count;
        n_last_freq    = r_last_freq;
        done           = 1'b0;
        if (i_req.kind == KIND_START) begin
            if (r_phase == PH_IDLE) begin
                n_bit_index    = BIT_W'(TRIM_BITS - 1);
                n_trim_value   = {1'b1, {(TRIM_BITS-1){1'b0}}};
                n_settle_count = '0;
                n_phase        = PH_SETTLE;
            end
        end else begin
            unique case (r_phase)
                PH_IDLE: ;
                PH_SETTLE: begin
                    if (r_settle_count >= i_cfg.settle_cycles) begin
                        n_phase = PH_WAIT;
                    end else begin
                        n_settle_count = r_settle_count + 1'b1;
                    end
                end
                PH_WAIT: begin
                    if (i_req.ref_edge) begin
                        n_tick_count = '0;
                        n_ref_count  = '0;
                        n_phase      = PH_MEAS;
                    end
                end
                PH_MEAS: begin
                    n_tick_count = tick_inc;
                    if (i_req.ref_edge) begin
                        n_ref_count = ref_inc;
                        if (ref_inc >= i_cfg.window_ref_edges) begin
                            n_last_freq  = scaled_sat;
                            n_trim_value = trim_kept;
                            if (r_bit_index == '0) begin
                                n_phase = PH_IDLE;
                                done    = 1'b1;
                            end else begin
                                n_bit_index    = bit_dec;
                                n_trim_value   = trim_kept | next_bit;
                                n_settle_count = '0;
                                n_phase        = PH_SETTLE;
                            end
                        end
                    end
                end
                default: n_phase = PH_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_IDLE;
            r_bit_index    <= '0;
            r_trim_value   <= '0;
            r_settle_count <= '0;
            r_ref_count    <= '0;
            r_tick_count   <= '0;
            r_last_freq    <= '0;
        end else if (i_fire) begin
            r_phase        <= n_phase;
            r_bit_index    <= n_bit_index;
            r_trim_value   <= n_trim_value;
            r_settle_count <= n_settle_count;
            r_ref_count    <= n_ref_count;
            r_tick_count   <= n_tick_count;
            r_last_freq    <= n_last_freq;
        end
    end

    assign trim_pad = {{TRIM_CODE_W{1'b0}}, n_trim_value};

    always_comb begin
        o_rsp.trim_code   = trim_pad[TRIM_CODE_W-1:0];
        o_rsp.busy_res    = (n_phase != PH_IDLE);
        o_rsp.done_res    = done;
        o_rsp.scaled_freq = n_last_freq;
    end

endmodule

### rtl/core/dco_frequency_calibrator.sv
// an accepted request is held in the request register, and its response then in the response register
// throughput: one request per cycle while the response is not stalled, each request yields exactly one response
// the input stalls only while both registers are full and the response is stalled
// reset (i_rst_n low, synchronous) empties both registers, idles the calibration
// state and restores all configuration registers to their defaults
module dco_frequency_calibrator
    import dfc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_req_valid,
    input  t_req                  i_req,
    output logic                  o_req_stall,
    output logic                  o_rsp_valid,
    output t_rsp                  o_rsp,
    input  logic                  i_rsp_stall,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_cfg cfg;
    t_rsp step_rsp;

    logic r_req_valid;
    t_req r_req;
    logic r_rsp_valid;
    t_rsp r_rsp;
    logic advance;
    logic fire;

    assign advance     = !r_rsp_valid || !i_rsp_stall;
    assign fire        = r_req_valid && advance;
    assign o_req_stall = r_req_valid && !advance;

    dfc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    dfc_sar_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_req   (r_req),
        .i_cfg   (cfg),
        .o_rsp   (step_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
        end else if (!o_req_stall) begin
            r_req_valid <= i_req_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_req_stall) begin
            r_req <= i_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (advance) begin
            r_rsp_valid <= r_req_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_rsp <= step_rsp;
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule
